[sv/fmtsp_pkg.sv]
package fmtsp_pkg;

  // saturation limit for width, precision and star magnitudes
  localparam int unsigned NumBits = 16;
  localparam logic [15:0] SatMax = 16'((64'd1 << NumBits) - 64'd1);

  // beat layout
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;

  // parser phases
  localparam logic [2:0] PhFlags   = 3'd0;
  localparam logic [2:0] PhWidDig  = 3'd1;
  localparam logic [2:0] PhAfterW  = 3'd2;
  localparam logic [2:0] PhPrecSt  = 3'd3;
  localparam logic [2:0] PhPrecDig = 3'd4;
  localparam logic [2:0] PhLen     = 3'd5;
  localparam logic [2:0] PhPair    = 3'd6;
  localparam logic [2:0] PhSpec    = 3'd7;

  // length modifier codes
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenH    = 3'd1;
  localparam logic [2:0] LenHH   = 3'd2;
  localparam logic [2:0] LenL    = 3'd3;
  localparam logic [2:0] LenLL   = 3'd4;
  localparam logic [2:0] LenZ    = 3'd5;
  localparam logic [2:0] LenJ    = 3'd6;
  localparam logic [2:0] LenT    = 3'd7;

  // flag bit positions
  localparam int unsigned FlagMinus = 0;
  localparam int unsigned FlagPlus  = 1;
  localparam int unsigned FlagSpace = 2;
  localparam int unsigned FlagHash  = 3;
  localparam int unsigned FlagZero  = 4;

  // characters
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChH     = 8'h68;
  localparam logic [7:0] ChL     = 8'h6c;
  localparam logic [7:0] ChZ     = 8'h7a;
  localparam logic [7:0] ChJ     = 8'h6a;
  localparam logic [7:0] ChT     = 8'h74;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // acc * 10 + digit, saturated
  function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] c);
    logic [19:0] nxt;
    nxt = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 20'(c - ChZero);
    if (nxt > 20'(SatMax)) begin
      return SatMax;
    end
    return nxt[15:0];
  endfunction

  // clamp a 32-bit magnitude
  function automatic logic [15:0] sat_mag(input logic [31:0] mag);
    if (mag > 32'(SatMax)) begin
      return SatMax;
    end
    return mag[15:0];
  endfunction

endpackage

[sv/format_spec_parser_top.sv]
// Conversion-specification parser: feed the characters that follow a percent
// sign, one per input beat, with the star argument beside each character. The
// block tracks flags, width, precision and length modifier; the conversion
// character (or a NUL) ends the spec and produces one output beat with every
// field, after which the parser is back at its reset state. One character is
// taken every cycle unless the output stalls: the parse step is a single pass
// of logic from the accepted beat and the parser registers into the output
// register, and a new beat is taken in the same cycle that a waiting result is
// drained. Width and precision saturate at 65535; precision reads -1 when absent.
module format_spec_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // ch [7:0], star_value [39:8]
  input  logic [fmtsp_pkg::InDataW-1:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // ljust [0], plus_sign [1], blank_sign [2], alt_form [3], pad_zero [4],
  // field_width [20:5], precision [37:21], length_code [40:38],
  // specifier [48:41], zero fill [55:49]
  output logic [fmtsp_pkg::OutDataW-1:0] m_axis_tdata_o
);

  logic        s_fire;
  logic [7:0]  ch;
  logic [31:0] star;
  logic        star_neg;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  flags_q, flags_d;
  logic [15:0] wid_q, wid_d;
  logic [16:0] prec_q, prec_d;
  logic [2:0]  len_q, len_d;

  logic        emit;
  logic        done;
  logic [2:0]  p_cur;

  logic        out_vld_q;
  logic [55:0] out_data_q, out_data_d;

  assign ch       = s_axis_tdata_i[7:0];
  assign star     = s_axis_tdata_i[39:8];
  assign star_neg = star[31];

  // take a beat whenever the output register is free or draining
  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // one parse step
  always_comb begin
    phase_d = phase_q;
    flags_d = flags_q;
    wid_d   = wid_q;
    prec_d  = prec_q;
    len_d   = len_q;
    emit    = 1'b0;
    done    = 1'b0;
    p_cur   = phase_q;

    if (p_cur == fmtsp_pkg::PhSpec) begin
      emit = 1'b1;
      done = 1'b1;
    end else if (p_cur == fmtsp_pkg::PhPair) begin
      done = 1'b1;
      if (len_q == fmtsp_pkg::LenH && ch == fmtsp_pkg::ChH) begin
        len_d   = fmtsp_pkg::LenHH;
        phase_d = fmtsp_pkg::PhSpec;
      end else if (len_q == fmtsp_pkg::LenL && ch == fmtsp_pkg::ChL) begin
        len_d   = fmtsp_pkg::LenLL;
        phase_d = fmtsp_pkg::PhSpec;
      end else begin
        emit = 1'b1;
      end
    end

    // flags, star width or first width digit
    if (!done && p_cur == fmtsp_pkg::PhFlags) begin
      done = 1'b1;
      if (ch == fmtsp_pkg::ChMinus) begin
        flags_d[fmtsp_pkg::FlagMinus] = 1'b1;
      end else if (ch == fmtsp_pkg::ChPlus) begin
        flags_d[fmtsp_pkg::FlagPlus] = 1'b1;
      end else if (ch == fmtsp_pkg::ChSpace) begin
        flags_d[fmtsp_pkg::FlagSpace] = 1'b1;
      end else if (ch == fmtsp_pkg::ChHash) begin
        flags_d[fmtsp_pkg::FlagHash] = 1'b1;
      end else if (ch == fmtsp_pkg::ChZero) begin
        flags_d[fmtsp_pkg::FlagZero] = 1'b1;
      end else if (ch == fmtsp_pkg::ChStar) begin
        if (star_neg) begin
          flags_d[fmtsp_pkg::FlagMinus] = 1'b1;
          wid_d = fmtsp_pkg::sat_mag(32'd0 - star);
        end else begin
          wid_d = fmtsp_pkg::sat_mag(star);
        end
        phase_d = fmtsp_pkg::PhAfterW;
      end else if (fmtsp_pkg::is_digit(ch)) begin
        wid_d   = fmtsp_pkg::acc_digit(wid_q, ch);
        phase_d = fmtsp_pkg::PhWidDig;
      end else begin
        done  = 1'b0;
        p_cur = fmtsp_pkg::PhAfterW;
      end
    end

    // further width digits
    if (!done && p_cur == fmtsp_pkg::PhWidDig) begin
      if (fmtsp_pkg::is_digit(ch)) begin
        wid_d = fmtsp_pkg::acc_digit(wid_q, ch);
        done  = 1'b1;
      end else begin
        p_cur = fmtsp_pkg::PhAfterW;
      end
    end

    // dot opens the precision
    if (!done && p_cur == fmtsp_pkg::PhAfterW) begin
      if (ch == fmtsp_pkg::ChDot) begin
        prec_d  = '0;
        phase_d = fmtsp_pkg::PhPrecSt;
        done    = 1'b1;
      end else begin
        p_cur = fmtsp_pkg::PhLen;
      end
    end

    // star precision or first precision digit
    if (!done && p_cur == fmtsp_pkg::PhPrecSt) begin
      if (ch == fmtsp_pkg::ChStar) begin
        prec_d  = star_neg ? '1 : {1'b0, fmtsp_pkg::sat_mag(star)};
        phase_d = fmtsp_pkg::PhLen;
        done    = 1'b1;
      end else if (fmtsp_pkg::is_digit(ch)) begin
        prec_d  = {1'b0, fmtsp_pkg::acc_digit(16'd0, ch)};
        phase_d = fmtsp_pkg::PhPrecDig;
        done    = 1'b1;
      end else begin
        p_cur = fmtsp_pkg::PhLen;
      end
    end

    // further precision digits
    if (!done && p_cur == fmtsp_pkg::PhPrecDig) begin
      if (fmtsp_pkg::is_digit(ch)) begin
        prec_d = {1'b0, fmtsp_pkg::acc_digit(prec_q[16] ? 16'd0 : prec_q[15:0], ch)};
        done   = 1'b1;
      end
    end

    // length modifier, else the conversion character
    if (!done) begin
      if (ch == fmtsp_pkg::ChH) begin
        len_d   = fmtsp_pkg::LenH;
        phase_d = fmtsp_pkg::PhPair;
      end else if (ch == fmtsp_pkg::ChL) begin
        len_d   = fmtsp_pkg::LenL;
        phase_d = fmtsp_pkg::PhPair;
      end else if (ch == fmtsp_pkg::ChZ) begin
        len_d   = fmtsp_pkg::LenZ;
        phase_d = fmtsp_pkg::PhSpec;
      end else if (ch == fmtsp_pkg::ChJ) begin
        len_d   = fmtsp_pkg::LenJ;
        phase_d = fmtsp_pkg::PhSpec;
      end else if (ch == fmtsp_pkg::ChT) begin
        len_d   = fmtsp_pkg::LenT;
        phase_d = fmtsp_pkg::PhSpec;
      end else begin
        emit = 1'b1;
      end
    end

    // result from the state gathered so far, then back to reset
    out_data_d = {7'd0, ch, len_q, prec_q, wid_q, flags_q};
    if (emit) begin
      phase_d = fmtsp_pkg::PhFlags;
      flags_d = '0;
      wid_d   = '0;
      prec_d  = '1;
      len_d   = fmtsp_pkg::LenNone;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fmtsp_pkg::PhFlags;
      flags_q <= '0;
      wid_q   <= '0;
      prec_q  <= '1;
      len_q   <= fmtsp_pkg::LenNone;
    end else if (s_fire) begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      wid_q   <= wid_d;
      prec_q  <= prec_d;
      len_q   <= len_d;
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_fire) begin
      out_vld_q <= emit;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // a NUL always closes the spec
  a_nul_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && ch == fmtsp_pkg::ChNul |=> m_axis_tvalid_o)
    else $error("NUL beat gave no result");

  // parser is back at reset after a result
  a_emit_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && emit |=> phase_q == fmtsp_pkg::PhFlags && prec_q == '1 && flags_q == '0)
    else $error("parser not reset after result");

  // precision is -1 or non-negative
  a_prec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prec_q[16] |-> prec_q == '1)
    else $error("precision below -1");

  // pair phase only after a single h or l
  a_pair_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == fmtsp_pkg::PhPair |-> len_q == fmtsp_pkg::LenH || len_q == fmtsp_pkg::LenL)
    else $error("pair phase with bad length code");

endmodule

[dv/tb_format_spec_parser_top.sv]
module tb_format_spec_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one parsed conversion spec, laid out as on m_axis_tdata_o[48:0]
  typedef struct packed {
    logic [7:0]         specifier;
    logic [2:0]         length_code;
    logic signed [16:0] precision;
    logic [15:0]        field_width;
    logic               pad_zero;
    logic               alt_form;
    logic               blank_sign;
    logic               plus_sign;
    logic               ljust;
  } spec_t;

  localparam int unsigned SatLimit = (1 << fmtsp_pkg::NumBits) - 1;
  localparam logic signed [16:0] NoPrec = -17'sd1;
  localparam logic [7:0] ChConvD = "d";
  localparam logic [7:0] ChConvS = "s";
  localparam logic [7:0] ChConvU = "u";
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [55:0] m_axis_tdata_o;

  // parser state mirror
  logic [2:0]         st_phase;
  logic [4:0]         st_flags;
  logic [15:0]        st_width;
  logic signed [16:0] st_prec;
  logic [2:0]         st_len;

  spec_t pending_specs[$];
  int    mismatches = 0;
  int    chars_sent = 0;
  int    stall_cycles = 0;
  int    hold_left = 0;
  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  string conv_chars = "diouxXeEfFgGaAcsp%n";

  format_spec_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit is_dec(input logic [7:0] c);
    return (c >= fmtsp_pkg::ChZero) && (c <= fmtsp_pkg::ChNine);
  endfunction

  // acc * 10 + digit, clamped to the saturation limit
  function automatic logic [15:0] dec_push(input logic [15:0] acc, input logic [7:0] c);
    int unsigned v;
    v = 32'(acc) * 10 + 32'(c - fmtsp_pkg::ChZero);
    if (v > SatLimit) v = SatLimit;
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_mag(input logic [31:0] m);
    if (m > SatLimit) return 16'(SatLimit);
    return m[15:0];
  endfunction

  task automatic reset_parser();
    st_phase = fmtsp_pkg::PhFlags;
    st_flags = '0;
    st_width = '0;
    st_prec  = NoPrec;
    st_len   = fmtsp_pkg::LenNone;
  endtask

  // advance the parser mirror by one character
  task automatic parse_char(input logic [7:0] c, input logic [31:0] star,
                            output bit done, output spec_t res);
    logic [2:0] ph;
    bit taken;
    done  = 1'b0;
    taken = 1'b0;
    res   = '0;
    ph    = st_phase;
    if (ph == fmtsp_pkg::PhSpec) begin
      done = 1'b1;
    end else if (ph == fmtsp_pkg::PhPair) begin
      if (st_len == fmtsp_pkg::LenH && c == fmtsp_pkg::ChH) begin
        st_len = fmtsp_pkg::LenHH;
        st_phase = fmtsp_pkg::PhSpec;
      end else if (st_len == fmtsp_pkg::LenL && c == fmtsp_pkg::ChL) begin
        st_len = fmtsp_pkg::LenLL;
        st_phase = fmtsp_pkg::PhSpec;
      end else begin
        done = 1'b1;
      end
    end else begin
      // flags, star width or first width digit
      if (ph == fmtsp_pkg::PhFlags) begin
        taken = 1'b1;
        case (c)
          fmtsp_pkg::ChMinus: st_flags[fmtsp_pkg::FlagMinus] = 1'b1;
          fmtsp_pkg::ChPlus:  st_flags[fmtsp_pkg::FlagPlus]  = 1'b1;
          fmtsp_pkg::ChSpace: st_flags[fmtsp_pkg::FlagSpace] = 1'b1;
          fmtsp_pkg::ChHash:  st_flags[fmtsp_pkg::FlagHash]  = 1'b1;
          fmtsp_pkg::ChZero:  st_flags[fmtsp_pkg::FlagZero]  = 1'b1;
          fmtsp_pkg::ChStar: begin
            if (star[31]) begin
              st_flags[fmtsp_pkg::FlagMinus] = 1'b1;
              st_width = clamp_mag(32'd0 - star);
            end else begin
              st_width = clamp_mag(star);
            end
            st_phase = fmtsp_pkg::PhAfterW;
          end
          default: begin
            if (is_dec(c)) begin
              st_width = dec_push(st_width, c);
              st_phase = fmtsp_pkg::PhWidDig;
            end else begin
              taken = 1'b0;
              ph = fmtsp_pkg::PhAfterW;
            end
          end
        endcase
      end
      if (!taken && ph == fmtsp_pkg::PhWidDig) begin
        if (is_dec(c)) begin
          st_width = dec_push(st_width, c);
          taken = 1'b1;
        end else begin
          ph = fmtsp_pkg::PhAfterW;
        end
      end
      // dot opens the precision with value zero
      if (!taken && ph == fmtsp_pkg::PhAfterW) begin
        if (c == fmtsp_pkg::ChDot) begin
          st_prec = '0;
          st_phase = fmtsp_pkg::PhPrecSt;
          taken = 1'b1;
        end else begin
          ph = fmtsp_pkg::PhLen;
        end
      end
      if (!taken && ph == fmtsp_pkg::PhPrecSt) begin
        if (c == fmtsp_pkg::ChStar) begin
          st_prec = star[31] ? NoPrec : {1'b0, clamp_mag(star)};
          st_phase = fmtsp_pkg::PhLen;
          taken = 1'b1;
        end else if (is_dec(c)) begin
          st_prec = {1'b0, dec_push(16'd0, c)};
          st_phase = fmtsp_pkg::PhPrecDig;
          taken = 1'b1;
        end else begin
          ph = fmtsp_pkg::PhLen;
        end
      end
      if (!taken && ph == fmtsp_pkg::PhPrecDig && is_dec(c)) begin
        st_prec = {1'b0, dec_push(st_prec < 0 ? 16'd0 : st_prec[15:0], c)};
        taken = 1'b1;
      end
      // length modifier or conversion character
      if (!taken) begin
        case (c)
          fmtsp_pkg::ChH: begin st_len = fmtsp_pkg::LenH; st_phase = fmtsp_pkg::PhPair; end
          fmtsp_pkg::ChL: begin st_len = fmtsp_pkg::LenL; st_phase = fmtsp_pkg::PhPair; end
          fmtsp_pkg::ChZ: begin st_len = fmtsp_pkg::LenZ; st_phase = fmtsp_pkg::PhSpec; end
          fmtsp_pkg::ChJ: begin st_len = fmtsp_pkg::LenJ; st_phase = fmtsp_pkg::PhSpec; end
          fmtsp_pkg::ChT: begin st_len = fmtsp_pkg::LenT; st_phase = fmtsp_pkg::PhSpec; end
          default: done = 1'b1;
        endcase
      end
    end
    if (done) begin
      res.ljust       = st_flags[fmtsp_pkg::FlagMinus];
      res.plus_sign   = st_flags[fmtsp_pkg::FlagPlus];
      res.blank_sign  = st_flags[fmtsp_pkg::FlagSpace];
      res.alt_form    = st_flags[fmtsp_pkg::FlagHash];
      res.pad_zero    = st_flags[fmtsp_pkg::FlagZero];
      res.field_width = st_width;
      res.precision   = st_prec;
      res.length_code = st_len;
      res.specifier   = c;
      reset_parser();
    end
  endtask

  // one character beat on the input side, with optional leading gap
  task automatic send_beat(input logic [7:0] c, input logic [31:0] star);
    bit    done;
    spec_t res;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {star, c};
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_char(c, star, done, res);
    if (done) pending_specs.push_back(res);
    chars_sent++;
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_specs.size() != 0);
  endtask

  function automatic logic [31:0] rand_star();
    case ($urandom_range(5))
      0: return 32'($urandom_range(99));
      1: return 32'd0 - 32'($urandom_range(99, 1));
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(65540, 65530));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(4))
      0: return fmtsp_pkg::ChMinus;
      1: return fmtsp_pkg::ChPlus;
      2: return fmtsp_pkg::ChSpace;
      3: return fmtsp_pkg::ChHash;
      default: return fmtsp_pkg::ChZero;
    endcase
  endfunction

  // mostly short digit runs, a few long enough to saturate
  task automatic send_digits(input bit nonzero_lead);
    int cnt;
    cnt = ($urandom_range(7) == 0) ? $urandom_range(6, 4) : $urandom_range(2, 1);
    if (nonzero_lead) begin
      send_beat(fmtsp_pkg::ChZero + 8'($urandom_range(9, 1)), rand_star());
      cnt--;
    end
    repeat (cnt) send_beat(fmtsp_pkg::ChZero + 8'($urandom_range(9)), rand_star());
  endtask

  // well-formed spec with random content, or a burst of random bytes
  task automatic send_random_spec();
    int pick;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(5, 1)) send_beat(8'($urandom_range(255)), rand_star());
    end else begin
      repeat ($urandom_range(3)) send_beat(pick_flag(), rand_star());
      case ($urandom_range(2))
        1: send_digits(1'b1);
        2: send_beat(fmtsp_pkg::ChStar, rand_star());
        default: ;
      endcase
      if ($urandom_range(1) == 1) begin
        send_beat(fmtsp_pkg::ChDot, rand_star());
        case ($urandom_range(2))
          1: send_digits(1'b0);
          2: send_beat(fmtsp_pkg::ChStar, rand_star());
          default: ;
        endcase
      end
      case ($urandom_range(7))
        1: send_beat(fmtsp_pkg::ChH, rand_star());
        2: begin
          send_beat(fmtsp_pkg::ChH, rand_star());
          send_beat(fmtsp_pkg::ChH, rand_star());
        end
        3: send_beat(fmtsp_pkg::ChL, rand_star());
        4: begin
          send_beat(fmtsp_pkg::ChL, rand_star());
          send_beat(fmtsp_pkg::ChL, rand_star());
        end
        5: send_beat(fmtsp_pkg::ChZ, rand_star());
        6: send_beat(fmtsp_pkg::ChJ, rand_star());
        7: send_beat(fmtsp_pkg::ChT, rand_star());
        default: ;
      endcase
      pick = $urandom_range(9);
      if (pick < 7) begin
        send_beat(conv_chars[$urandom_range(conv_chars.len() - 1)], rand_star());
      end else if (pick < 8) begin
        send_beat(fmtsp_pkg::ChNul, rand_star());
      end else begin
        send_beat(8'($urandom_range(255)), rand_star());
      end
    end
  endtask

  task automatic note_mismatch(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  task automatic check_spec(input spec_t want, input logic [55:0] beat);
    spec_t got;
    got = spec_t'(beat[48:0]);
    if (beat[55:49] !== '0) note_mismatch("zero fill", 32'd0, 32'(beat[55:49]));
    if (got.ljust !== want.ljust)
      note_mismatch("ljust", 32'(want.ljust), 32'(got.ljust));
    if (got.plus_sign !== want.plus_sign)
      note_mismatch("plus_sign", 32'(want.plus_sign), 32'(got.plus_sign));
    if (got.blank_sign !== want.blank_sign)
      note_mismatch("blank_sign", 32'(want.blank_sign), 32'(got.blank_sign));
    if (got.alt_form !== want.alt_form)
      note_mismatch("alt_form", 32'(want.alt_form), 32'(got.alt_form));
    if (got.pad_zero !== want.pad_zero)
      note_mismatch("pad_zero", 32'(want.pad_zero), 32'(got.pad_zero));
    if (got.field_width !== want.field_width)
      note_mismatch("field_width", 32'(want.field_width), 32'(got.field_width));
    if (got.precision !== want.precision)
      note_mismatch("precision", 32'(want.precision), 32'(got.precision));
    if (got.length_code !== want.length_code)
      note_mismatch("length_code", 32'(want.length_code), 32'(got.length_code));
    if (got.specifier !== want.specifier)
      note_mismatch("specifier", 32'(want.specifier), 32'(got.specifier));
  endtask

  // result side: random or held-off ready
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result beat with the oldest expected spec
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending_specs.size() == 0) begin
        $display("%0t: result beat expected none actual %h", $time, m_axis_tdata_o);
        mismatches++;
      end else begin
        check_spec(pending_specs.pop_front(), m_axis_tdata_o);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // all five flags then a conversion
  task automatic test_flags();
    send_beat(fmtsp_pkg::ChMinus, rand_star());
    send_beat(fmtsp_pkg::ChPlus, rand_star());
    send_beat(fmtsp_pkg::ChSpace, rand_star());
    send_beat(fmtsp_pkg::ChHash, rand_star());
    send_beat(fmtsp_pkg::ChZero, rand_star());
    send_beat(ChConvD, rand_star());
  endtask

  // most negative star width, negative star precision
  task automatic test_star_args();
    send_beat(fmtsp_pkg::ChStar, 32'h8000_0000);
    send_beat(fmtsp_pkg::ChDot, rand_star());
    send_beat(fmtsp_pkg::ChStar, 32'hffff_fffb);
    send_beat(ChConvS, rand_star());
  endtask

  // width digits past the limit, bare dot, hh
  task automatic test_saturation();
    repeat (5) send_beat(fmtsp_pkg::ChNine, rand_star());
    send_beat(fmtsp_pkg::ChDot, rand_star());
    send_beat(fmtsp_pkg::ChH, rand_star());
    send_beat(fmtsp_pkg::ChH, rand_star());
    send_beat(ChConvU, rand_star());
  endtask

  // star after width digits, nul after single l, lone nul
  task automatic test_terminators();
    send_beat(fmtsp_pkg::ChZero + 8'd5, rand_star());
    send_beat(fmtsp_pkg::ChStar, 32'h7fff_ffff);
    send_beat(fmtsp_pkg::ChStar, 32'h7fff_ffff);
    send_beat(fmtsp_pkg::ChL, rand_star());
    send_beat(fmtsp_pkg::ChNul, rand_star());
    send_beat(fmtsp_pkg::ChNul, 32'hffff_ffff);
  endtask

  // long receiver hold-off while the sender keeps pushing one-beat specs
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left = HoldCycles;
    repeat (12) send_beat(ChConvD, rand_star());
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random(input int items, input int tx_pct, input int rx_pct);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = chars_sent;
    while (chars_sent - start < items) send_random_spec();
    stop_sending();
    wait_drained();
  endtask

  initial begin
    reset_parser();
    tx_idle_pct = 27;
    rx_idle_pct = 83;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_flags();
    test_star_args();
    test_saturation();
    test_terminators();
    stop_sending();
    wait_drained();
    test_backpressure();
    test_random(134, 27, 83);
    test_random(133, 83, 27);
    test_random(133, 0, 0);

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_specs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[format_spec_parser_top.f]
sv/fmtsp_pkg.sv
sv/format_spec_parser_top.sv
dv/tb_format_spec_parser_top.sv
